FILE: design/assert_macros.svh
// Assertion macros shared by the peak decimator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dcpd_pkg.sv
// Shared constants, types and register codes of the dual channel peak decimator.
package dcpd_pkg;

    localparam int MAX_WINDOW     = 4096;
    localparam int MAX_DELAY      = 4096;
    localparam int SAMPLE_BITS    = 24;
    localparam int BUF_DEPTH      = MAX_WINDOW + MAX_DELAY;
    localparam int ADDR_BITS      = $clog2(BUF_DEPTH);
    localparam int FILL_BITS      = $clog2(BUF_DEPTH + 2);
    localparam int CFG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int WIN_BITS       = $clog2(MAX_WINDOW + 1);
    localparam int PHASE_BITS     = $clog2(MAX_WINDOW);
    localparam int ZR_BITS        = $clog2(MAX_DELAY + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LEN  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAYED_CH = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Scan control from the sequencer to the extreme tracker.
    typedef struct packed {
        logic valid;
        logic first;
        logic zero_a;
        logic zero_b;
        logic load;
        logic short_a;
        logic short_b;
    } scan_ctl_t;

endpackage

FILE: design/dcpd_ram.sv
// Generic simple dual port RAM with registered read.
module dcpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/dcpd_ctrl.sv
// Sequencer: configuration, buffer pointers, fills, window phase and scan addressing.
module dcpd_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dcpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dcpd_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic                                   out_busy,
    output logic                                   wr_en,
    output logic [dcpd_pkg::ADDR_BITS-1:0]         wr_addr_a,
    output logic [dcpd_pkg::ADDR_BITS-1:0]         wr_addr_b,
    output logic [dcpd_pkg::ADDR_BITS-1:0]         rd_addr,
    output dcpd_pkg::scan_ctl_t                    scan
);
    import dcpd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CFG_BITS-1:0]   window_len_reg, window_len_next;
    logic [CFG_BITS-1:0]   delay_len_reg, delay_len_next;
    logic                  delayed_ch_reg, delayed_ch_next;
    logic [ADDR_BITS-1:0]  head_reg, head_next;
    logic [FILL_BITS-1:0]  fill_a_reg, fill_a_next;
    logic [FILL_BITS-1:0]  fill_b_reg, fill_b_next;
    logic [ZR_BITS-1:0]    zr_a_reg, zr_a_next;
    logic [ZR_BITS-1:0]    zr_b_reg, zr_b_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  started_reg, started_next;
    logic [WIN_BITS-1:0]   k_reg, k_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  rd_first_reg, rd_first_next;
    logic                  rd_zero_a_reg, rd_zero_a_next;
    logic                  rd_zero_b_reg, rd_zero_b_next;

    logic [WIN_BITS-1:0]   win;
    logic [ZR_BITS-1:0]    delay_eff;
    logic                  accept;
    logic                  cfg_hit;
    logic                  drop;
    logic [FILL_BITS-1:0]  fa_inc, fb_inc;
    logic [WIN_BITS-1:0]   phase_inc;

    // Clamp the window register to its legal range.
    always_comb
    begin
        if (window_len_reg < CFG_BITS'(2))
        begin
            win = WIN_BITS'(2);
        end
        else if (window_len_reg > CFG_BITS'(MAX_WINDOW))
        begin
            win = WIN_BITS'(MAX_WINDOW);
        end
        else
        begin
            win = WIN_BITS'(window_len_reg);
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign cfg_hit      = cfg_we && (cfg_index == REG_WINDOW_LEN ||
                                     cfg_index == REG_DELAY_LEN ||
                                     cfg_index == REG_DELAYED_CH);
    assign fa_inc       = fill_a_reg + FILL_BITS'(1);
    assign fb_inc       = fill_b_reg + FILL_BITS'(1);
    assign drop         = (fa_inc > FILL_BITS'(win)) && (fb_inc > FILL_BITS'(win));
    assign phase_inc    = WIN_BITS'(phase_reg) + WIN_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        window_len_next = window_len_reg;
        delay_len_next  = delay_len_reg;
        delayed_ch_next = delayed_ch_reg;
        head_next       = head_reg;
        fill_a_next     = fill_a_reg;
        fill_b_next     = fill_b_reg;
        zr_a_next       = zr_a_reg;
        zr_b_next       = zr_b_reg;
        phase_next      = phase_reg;
        started_next    = started_reg;
        k_next          = k_reg;
        delay_eff       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Push into both buffers, then drop the oldest pair if both overflow.
                    if (drop)
                    begin
                        head_next   = head_reg + ADDR_BITS'(1);
                        fill_a_next = fill_a_reg;
                        fill_b_next = fill_b_reg;
                        if (zr_a_reg != '0)
                        begin
                            zr_a_next = zr_a_reg - ZR_BITS'(1);
                        end
                        if (zr_b_reg != '0)
                        begin
                            zr_b_next = zr_b_reg - ZR_BITS'(1);
                        end
                    end
                    else
                    begin
                        fill_a_next = fa_inc;
                        fill_b_next = fb_inc;
                    end
                    started_next = 1'b1;
                    if (phase_inc >= win)
                    begin
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_inc[PHASE_BITS-1:0];
                    end
                    if (phase_reg == '0 && started_reg)
                    begin
                        state_next = ST_SCAN;
                        k_next     = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                k_next = k_reg + WIN_BITS'(1);
                if (k_reg == win - WIN_BITS'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A write to any of the three listed registers restarts the buffers with the new settings.
        if (cfg_hit)
        begin
            case (cfg_index)
                REG_WINDOW_LEN: window_len_next = cfg_data;
                REG_DELAY_LEN:  delay_len_next  = cfg_data;
                REG_DELAYED_CH: delayed_ch_next = cfg_data[0];
                default:        window_len_next = window_len_reg;
            endcase
            if (delay_len_next > CFG_BITS'(MAX_DELAY))
            begin
                delay_eff = ZR_BITS'(MAX_DELAY);
            end
            else
            begin
                delay_eff = ZR_BITS'(delay_len_next);
            end
            state_next   = ST_IDLE;
            head_next    = '0;
            fill_a_next  = delayed_ch_next ? '0 : FILL_BITS'(delay_eff);
            fill_b_next  = delayed_ch_next ? FILL_BITS'(delay_eff) : '0;
            zr_a_next    = delayed_ch_next ? '0 : delay_eff;
            zr_b_next    = delayed_ch_next ? delay_eff : '0;
            phase_next   = '0;
            started_next = 1'b0;
            k_next       = '0;
        end
    end

    assign rd_valid_next  = (state_reg == ST_SCAN);
    assign rd_first_next  = (k_reg == '0);
    assign rd_zero_a_next = (FILL_BITS'(k_reg) < FILL_BITS'(zr_a_reg));
    assign rd_zero_b_next = (FILL_BITS'(k_reg) < FILL_BITS'(zr_b_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= CFG_BITS'(2);
            delay_len_reg  <= '0;
            delayed_ch_reg <= 1'b0;
            head_reg       <= '0;
            fill_a_reg     <= '0;
            fill_b_reg     <= '0;
            zr_a_reg       <= '0;
            zr_b_reg       <= '0;
            phase_reg      <= '0;
            started_reg    <= 1'b0;
            k_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_zero_a_reg  <= 1'b0;
            rd_zero_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            delay_len_reg  <= delay_len_next;
            delayed_ch_reg <= delayed_ch_next;
            head_reg       <= head_next;
            fill_a_reg     <= fill_a_next;
            fill_b_reg     <= fill_b_next;
            zr_a_reg       <= zr_a_next;
            zr_b_reg       <= zr_b_next;
            phase_reg      <= phase_next;
            started_reg    <= started_next;
            k_reg          <= k_next;
            rd_valid_reg   <= rd_valid_next;
            rd_first_reg   <= rd_first_next;
            rd_zero_a_reg  <= rd_zero_a_next;
            rd_zero_b_reg  <= rd_zero_b_next;
        end
    end

    assign wr_en     = accept;
    assign wr_addr_a = head_reg + fill_a_reg[ADDR_BITS-1:0];
    assign wr_addr_b = head_reg + fill_b_reg[ADDR_BITS-1:0];
    assign rd_addr   = head_reg + ADDR_BITS'(k_reg);

    assign scan.valid   = rd_valid_reg;
    assign scan.first   = rd_first_reg;
    assign scan.zero_a  = rd_zero_a_reg;
    assign scan.zero_b  = rd_zero_b_reg;
    assign scan.load    = (state_reg == ST_LOAD) && !out_busy;
    assign scan.short_a = (fill_a_reg < FILL_BITS'(win));
    assign scan.short_b = (fill_b_reg < FILL_BITS'(win));

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_fill_bound, fill_a_reg <= FILL_BITS'(BUF_DEPTH) && fill_b_reg <= FILL_BITS'(BUF_DEPTH), "buffer fill beyond depth")
    `ASSERT_IMPLY(a_idle_fill, state_reg == ST_IDLE, fill_a_reg <= FILL_BITS'(win) || fill_b_reg <= FILL_BITS'(win), "both buffers longer than window")
    `ASSERT_IMPLY(a_scan_start, state_reg == ST_SCAN && !$past(state_reg == ST_SCAN), k_reg == '0, "scan did not start at first entry")

endmodule

FILE: design/dcpd_peak.sv
// Extreme tracker over the scanned window and the two-result output stage.
module dcpd_peak (
    input  logic                clk,
    input  logic                rst_n,
    input  dcpd_pkg::scan_ctl_t scan,
    input  dcpd_pkg::sample_t   rd_data_a,
    input  dcpd_pkg::sample_t   rd_data_b,
    output logic                out_busy,
    output logic                peak_valid,
    input  logic                peak_ready,
    output dcpd_pkg::sample_t   peak_a,
    output dcpd_pkg::sample_t   peak_b,
    output logic                is_minimum,
    output logic                last
);
    import dcpd_pkg::*;

    sample_t va, vb;
    sample_t max_a_reg, max_a_next, min_a_reg, min_a_next;
    sample_t max_b_reg, max_b_next, min_b_reg, min_b_next;
    sample_t omax_a_reg, omax_b_reg, omin_a_reg, omin_b_reg;
    logic    out_valid_reg, out_valid_next;
    logic    sel_reg, sel_next;

    // Preloaded entries of the delayed channel read as zero.
    assign va = scan.zero_a ? '0 : rd_data_a;
    assign vb = scan.zero_b ? '0 : rd_data_b;

    always_comb
    begin
        max_a_next = max_a_reg;
        min_a_next = min_a_reg;
        max_b_next = max_b_reg;
        min_b_next = min_b_reg;
        if (scan.valid)
        begin
            if (scan.first || va > max_a_reg)
            begin
                max_a_next = va;
            end
            if (scan.first || va < min_a_reg)
            begin
                min_a_next = va;
            end
            if (scan.first || vb > max_b_reg)
            begin
                max_b_next = vb;
            end
            if (scan.first || vb < min_b_reg)
            begin
                min_b_next = vb;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        if (scan.load)
        begin
            out_valid_next = 1'b1;
            sel_next       = 1'b0;
        end
        else if (out_valid_reg && peak_ready)
        begin
            // Advance from the maximum pair to the minimum pair, then drain.
            if (!sel_reg)
            begin
                sel_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        max_a_reg <= max_a_next;
        min_a_reg <= min_a_next;
        max_b_reg <= max_b_next;
        min_b_reg <= min_b_next;
        if (scan.load)
        begin
            omax_a_reg <= scan.short_a ? '0 : max_a_reg;
            omin_a_reg <= scan.short_a ? '0 : min_a_reg;
            omax_b_reg <= scan.short_b ? '0 : max_b_reg;
            omin_b_reg <= scan.short_b ? '0 : min_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    assign out_busy   = out_valid_reg;
    assign peak_valid = out_valid_reg;
    assign peak_a     = sel_reg ? omin_a_reg : omax_a_reg;
    assign peak_b     = sel_reg ? omin_b_reg : omax_b_reg;
    assign is_minimum = sel_reg;
    assign last       = sel_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_load_free, scan.load, !out_valid_reg, "window loaded over pending results")
    `ASSERT_NEXT(a_min_follows, out_valid_reg && peak_ready && !sel_reg, out_valid_reg && sel_reg, "minimum pair did not follow maximum pair")

endmodule

FILE: design/dual_channel_peak_decimator.sv
// Top level of the dual channel peak decimator.
//
// Each item on the sample channel (sample_valid/sample_ready) carries one
// sample per channel; both are appended to per-channel circular buffers held
// in two 8192 x 24 RAMs. Every window_len samples, the block scans the oldest
// window_len entries of each buffer and emits two items on the peak channel
// (peak_valid/peak_ready): the maximum pair, then the minimum pair with last
// set. A channel with fewer than window_len entries reports 0.
// An item that closes no window does not hold the sample channel. An item
// that closes a window holds further items off until the window is done:
// the scan reads one entry per cycle through the RAM read port, then a drain
// state covers the read register and a load state fills the output stage.
// The output stage holds both results; items are accepted while it drains,
// but the next window load waits until the receiver has taken both results.
// Reset and any write to a listed register restart the buffers: the delayed
// channel is preloaded with delay_len zeros by count, with no RAM clearing.
module dual_channel_peak_decimator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dcpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcpd_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  dcpd_pkg::sample_t                   sample_a,
    input  dcpd_pkg::sample_t                   sample_b,
    output logic                                peak_valid,
    input  logic                                peak_ready,
    output dcpd_pkg::sample_t                   peak_a,
    output dcpd_pkg::sample_t                   peak_b,
    output logic                                is_minimum,
    output logic                                last
);
    import dcpd_pkg::*;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr_a, wr_addr_b, rd_addr;
    logic                 out_busy;
    scan_ctl_t            scan;
    sample_t              rd_data_a, rd_data_b;

    dcpd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .out_busy     (out_busy),
        .wr_en        (wr_en),
        .wr_addr_a    (wr_addr_a),
        .wr_addr_b    (wr_addr_b),
        .rd_addr      (rd_addr),
        .scan         (scan)
    );

    dcpd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUF_DEPTH)
    ) u_buf_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr_a),
        .wdata (sample_a),
        .raddr (rd_addr),
        .rdata (rd_data_a)
    );

    dcpd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUF_DEPTH)
    ) u_buf_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr_b),
        .wdata (sample_b),
        .raddr (rd_addr),
        .rdata (rd_data_b)
    );

    dcpd_peak u_peak (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b),
        .out_busy   (out_busy),
        .peak_valid (peak_valid),
        .peak_ready (peak_ready),
        .peak_a     (peak_a),
        .peak_b     (peak_b),
        .is_minimum (is_minimum),
        .last       (last)
    );

endmodule
